>>> hdl/i8gemm_pkg.sv
package i8gemm_pkg;

    // Largest tile edge that one step word can carry.
    localparam int unsigned MAX_DIM = 8;

    // Width of one operand byte and of one accumulated sum.
    localparam int unsigned OPND_W = 8;
    localparam int unsigned PROD_W = 16;
    localparam int unsigned SUM_W  = 32;
    localparam int unsigned IDX_W  = 3;

    // One k-step: a column of A and a row of B, byte 0 in the low bits.
    typedef struct packed {
        logic [MAX_DIM*OPND_W-1:0] a_column;
        logic [MAX_DIM*OPND_W-1:0] b_row;
        logic                      last_step;
    } step_word_t;

    // One tile element on its way out.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum_value;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic                    tile_done;
    } sum_word_t;

    // Status of the drain stage as seen by the lanes and the input side.
    typedef struct packed {
        logic busy;
        logic clear_tile;
    } drain_status_t;

endpackage

>>> hdl/i8gemm_mac_lane.sv
module i8gemm_mac_lane (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [i8gemm_pkg::OPND_W-1:0] a_byte,
    input  logic signed [i8gemm_pkg::OPND_W-1:0] b_byte,
    input  logic                                 acc_en,
    input  logic                                 clear,
    output logic [i8gemm_pkg::SUM_W-1:0]         sum
);

    logic signed [i8gemm_pkg::PROD_W-1:0] prod;
    logic [i8gemm_pkg::SUM_W-1:0]         prod_ext;
    logic [i8gemm_pkg::SUM_W-1:0]         base;
    logic [i8gemm_pkg::SUM_W-1:0]         acc_reg;
    logic [i8gemm_pkg::SUM_W-1:0]         acc_next;

    // Signed 8x8 product, sign-extended to the accumulator width.
    assign prod     = a_byte * b_byte;
    assign prod_ext = i8gemm_pkg::SUM_W'(prod);

    // Clearing drops the old sum; the add wraps modulo 2^32.
    assign base     = clear ? '0 : acc_reg;
    assign acc_next = base + (acc_en ? prod_ext : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (acc_en || clear)
        begin
            acc_reg <= acc_next;
        end
    end

    assign sum = acc_reg;

endmodule

>>> hdl/i8gemm_drain.sv
module i8gemm_drain #(
    parameter int unsigned TILE_ROWS = 8,
    parameter int unsigned TILE_COLS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [i8gemm_pkg::SUM_W-1:0]     sums [TILE_ROWS][TILE_COLS],
    input  logic                             sum_stall,
    output logic                             sum_valid,
    output i8gemm_pkg::sum_word_t            sum_word,
    output i8gemm_pkg::drain_status_t        status
);

    localparam int unsigned RIDX_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
    localparam int unsigned CIDX_W = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } drain_state_t;

    drain_state_t          state_reg;
    drain_state_t          state_next;
    logic [RIDX_W-1:0]     row_reg;
    logic [RIDX_W-1:0]     row_next;
    logic [CIDX_W-1:0]     col_reg;
    logic [CIDX_W-1:0]     col_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    i8gemm_pkg::sum_word_t out_word_reg;
    i8gemm_pkg::sum_word_t out_word_next;

    logic                  load;
    logic                  last_col;
    logic                  last_row;
    logic                  is_final;

    // A new element moves into the output register whenever it is free.
    assign load     = (state_reg == ST_DRAIN) && (!out_valid_reg || !sum_stall);
    assign last_col = (col_reg == CIDX_W'(TILE_COLS - 1));
    assign last_row = (row_reg == RIDX_W'(TILE_ROWS - 1));
    assign is_final = last_row && last_col;

    // Row-major walk over the lanes, selecting one sum a cycle unless the output is stalled.
    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        out_word_next = out_word_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                row_next = '0;
                col_next = '0;
                if (start)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (load)
                begin
                    out_word_next.sum_value = sums[row_reg][col_reg];
                    out_word_next.row_index = i8gemm_pkg::IDX_W'(row_reg);
                    out_word_next.col_index = i8gemm_pkg::IDX_W'(col_reg);
                    out_word_next.tile_done = is_final;
                    if (last_col)
                    begin
                        col_next = '0;
                        row_next = last_row ? '0 : row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    if (is_final)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                row_next   = '0;
                col_next   = '0;
            end
        endcase
    end

    // The output word stays until the receiver takes it.
    assign out_valid_next = load ? 1'b1 : (out_valid_reg && sum_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign sum_valid         = out_valid_reg;
    assign sum_word          = out_word_reg;
    assign status.busy       = (state_reg == ST_DRAIN);
    assign status.clear_tile = load && is_final;

    // The lanes are cleared only as the final element is loaded, and then the walk ends.
    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        status.clear_tile |=> (state_reg == ST_IDLE))
        else $error("drain did not return to idle after clearing the tile");

    // A new tile never starts while one is still being drained.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == ST_IDLE))
        else $error("drain started while busy");

    // The idle walk always restarts at the first element.
    a_idle_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (row_reg == '0 && col_reg == '0))
        else $error("drain counters not at origin while idle");

    // The done mark sits only on the bottom-right element.
    a_done_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid && sum_word.tile_done) |->
            (sum_word.row_index == i8gemm_pkg::IDX_W'(TILE_ROWS - 1) &&
             sum_word.col_index == i8gemm_pkg::IDX_W'(TILE_COLS - 1)))
        else $error("tile_done on an element other than the last");

endmodule

>>> hdl/int8_gemm_tile_accumulator.sv
// Output-stationary int8 GEMM tile with int32 accumulation.
//
// The step channel (step_valid, step_stall, step_word) carries one k-step a
// word: a column of A and a row of B, eight signed bytes each. A word is taken
// on a clock edge with step_valid high and step_stall low. Every lane then adds
// a[r]*b[c] into its own 32-bit accumulator, wrapping modulo 2^32.
// Plain k-steps are taken one per cycle while no drain runs and produce nothing.
// A word with last_step set is accumulated first, then the tile is drained on
// the sum channel (sum_valid, sum_stall, sum_word) in row-major order, one
// element a cycle while sum_stall is low; tile_done marks the final element.
// The last k-step puts the drain in its drain state, from which the first
// element is loaded into the output register. While the drain runs,
// step_stall is high, so no k-step is taken until the walk over the lanes
// through one output register has ended. A stall on the sum channel holds the
// current word and pauses the walk. The accumulators clear as the final element
// enters the output register, and the next tile may start the following cycle.
// Reset (rst_n low) zeroes all accumulators and drops any drain in progress.
module int8_gemm_tile_accumulator #(
    parameter int unsigned TILE_ROWS = 8,
    parameter int unsigned TILE_COLS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step_valid,
    output logic                      step_stall,
    input  i8gemm_pkg::step_word_t    step_word,
    output logic                      sum_valid,
    input  logic                      sum_stall,
    output i8gemm_pkg::sum_word_t     sum_word
);

    logic                          step_take;
    logic                          drain_start;
    i8gemm_pkg::drain_status_t     status;
    logic [i8gemm_pkg::SUM_W-1:0]  sums [TILE_ROWS][TILE_COLS];

    // Steps are held off while a finished tile is being drained.
    assign step_stall  = status.busy;
    assign step_take   = step_valid && !step_stall;
    assign drain_start = step_take && step_word.last_step;

    // One multiply-accumulate lane for each tile element.
    for (genvar r = 0; r < TILE_ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < TILE_COLS; c++)
        begin : g_col
            i8gemm_mac_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .a_byte (step_word.a_column[r*i8gemm_pkg::OPND_W +: i8gemm_pkg::OPND_W]),
                .b_byte (step_word.b_row[c*i8gemm_pkg::OPND_W +: i8gemm_pkg::OPND_W]),
                .acc_en (step_take),
                .clear  (status.clear_tile),
                .sum    (sums[r][c])
            );
        end
    end

    // Merging stage: serializes the lane sums onto the output channel.
    i8gemm_drain #(
        .TILE_ROWS (TILE_ROWS),
        .TILE_COLS (TILE_COLS)
    ) u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (drain_start),
        .sums      (sums),
        .sum_stall (sum_stall),
        .sum_valid (sum_valid),
        .sum_word  (sum_word),
        .status    (status)
    );

endmodule
